### hdl/nsc_pkg.sv
// ----------------------------------------------------------------------------
// nsc_pkg: shared types, constants and functions of the NMEA sentence checker
// Holds the parser state record, the raw result record and the small
// character and digit helpers used by the parser and the result stage.
// ----------------------------------------------------------------------------
package nsc_pkg;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UF     = 8'h46;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LF     = 8'h66;

	localparam logic [1:0] KIND_UNKNOWN = 2'd0;
	localparam logic [1:0] KIND_GGA     = 2'd1;
	localparam logic [1:0] KIND_RMC     = 2'd2;

	// Field numbers of the comma-separated body that carry data.
	localparam logic [3:0] FLD_ADDRESS = 4'd0;
	localparam logic [3:0] FLD_TIME    = 4'd1;
	localparam logic [3:0] FLD_STATUS  = 4'd2;
	localparam logic [3:0] FLD_QUALITY = 4'd6;
	localparam logic [3:0] FLD_SATS    = 4'd7;
	localparam logic [3:0] FLD_DATE    = 4'd9;

	localparam logic [3:0] ADDR_LEN  = 4'd5;
	localparam logic [3:0] COUNT_MAX = 4'd15;
	localparam logic [6:0] INT_MAX   = 7'd99;
	localparam logic [6:0] YEAR_WRAP = 7'd90;
	localparam logic [7:0] YEAR_ADD  = 8'd100;

	typedef struct packed {
		logic        in_sentence;
		logic [7:0]  xor_sum;
		logic        after_star;
		logic [1:0]  hex_digits_seen;
		logic [7:0]  sent_checksum;
		logic [3:0]  field_number;
		logic [3:0]  char_in_field;
		logic [1:0]  kind_match;      // bit 0 GGA still possible, bit 1 RMC
		logic        past_point;
		logic [23:0] time_digits;
		logic [23:0] date_digits;
		logic [6:0]  quality_value;
		logic [6:0]  satellite_value;
		logic        status_active;
	} parser_state_t;

	// Everything the result stage needs to format one sentence.
	typedef struct packed {
		logic [1:0]  kind;
		logic        checksum_ok;
		logic [23:0] time_digits;
		logic [23:0] date_digits;
		logic [6:0]  quality_value;
		logic [6:0]  satellite_value;
		logic        status_active;
	} raw_result_t;

	function automatic parser_state_t open_state();
		parser_state_t s;
		s                 = '0;
		s.in_sentence     = 1'b1;
		s.kind_match      = 2'b11;
		return s;
	endfunction

	function automatic parser_state_t idle_state();
		parser_state_t s;
		s             = open_state();
		s.in_sentence = 1'b0;
		return s;
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	// Bit 4 flags a valid hex digit, bits 3:0 hold its value.
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (is_digit(b)) begin
			r = {1'b1, b[3:0]};
		end else if ((b >= CH_UA) && (b <= CH_UF)) begin
			r = {1'b1, 4'(b - CH_UA + 8'd10)};
		end else if ((b >= CH_LA) && (b <= CH_LF)) begin
			r = {1'b1, 4'(b - CH_LA + 8'd10)};
		end
		return r;
	endfunction

	function automatic logic [7:0] gga_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0:    c = 8'h47; // G
			3'd1:    c = 8'h50; // P
			3'd2:    c = 8'h47; // G
			3'd3:    c = 8'h47; // G
			3'd4:    c = 8'h41; // A
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] rmc_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0:    c = 8'h47; // G
			3'd1:    c = 8'h50; // P
			3'd2:    c = 8'h52; // R
			3'd3:    c = 8'h4D; // M
			3'd4:    c = 8'h43; // C
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Accumulate one decimal digit, saturating at 99.
	function automatic logic [6:0] add_count(input logic [6:0] v, input logic [3:0] d);
		logic [9:0] n;
		n = ({3'd0, v} << 3) + ({3'd0, v} << 1) + {6'd0, d};
		return (n > 10'(INT_MAX)) ? INT_MAX : n[6:0];
	endfunction

	// Two BCD digits to a binary value.
	function automatic logic [6:0] digit_pair(input logic [7:0] bcd);
		logic [6:0] hi;
		hi = {3'd0, bcd[7:4]};
		return (hi << 3) + (hi << 1) + {3'd0, bcd[3:0]};
	endfunction

endpackage

### hdl/nsc_parser.sv
// ----------------------------------------------------------------------------
// nsc_parser: per-character sentence state and its update
// Holds the sentence state, folds one character into it per step and raises
// a result strobe with the raw fields when a sentence ends.
// ----------------------------------------------------------------------------
module nsc_parser import nsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  char_in,
	output logic        emit,
	output raw_result_t raw
);

	parser_state_t state_q;
	parser_state_t state_d;
	logic          emit_c;
	logic [4:0]    hex;
	logic [7:0]    sum_check;

	always_comb begin
		state_d   = state_q;
		emit_c    = 1'b0;
		hex       = hex_value(char_in);
		sum_check = state_q.sent_checksum;
		if (!state_q.in_sentence) begin
			if (char_in == CH_DOLLAR) begin
				state_d = open_state();
			end
		end else if (state_q.after_star) begin
			if (hex[4]) begin
				sum_check               = {state_q.sent_checksum[3:0], hex[3:0]};
				state_d.sent_checksum   = sum_check;
				state_d.hex_digits_seen = state_q.hex_digits_seen + 2'd1;
				if (state_q.hex_digits_seen != 2'd0) begin
					emit_c              = 1'b1;
					state_d.in_sentence = 1'b0;
				end
			end else begin
				// A non-hex byte closes the sentence; a dollar opens the next one.
				emit_c              = 1'b1;
				state_d.in_sentence = 1'b0;
				if (char_in == CH_DOLLAR) begin
					state_d = open_state();
				end
			end
		end else if (char_in == CH_DOLLAR) begin
			state_d = open_state();
		end else if (char_in == CH_STAR) begin
			if ((state_q.field_number == FLD_ADDRESS) && (state_q.char_in_field != ADDR_LEN)) begin
				state_d.kind_match = 2'b00;
			end
			state_d.after_star = 1'b1;
		end else begin
			state_d.xor_sum = state_q.xor_sum ^ char_in;
			if (char_in == CH_COMMA) begin
				if ((state_q.field_number == FLD_ADDRESS) &&
					(state_q.char_in_field != ADDR_LEN)) begin
					state_d.kind_match = 2'b00;
				end
				if (state_q.field_number != COUNT_MAX) begin
					state_d.field_number = state_q.field_number + 4'd1;
				end
				state_d.char_in_field = 4'd0;
				state_d.past_point    = 1'b0;
			end else begin
				case (state_q.field_number)
					FLD_ADDRESS: begin
						if (state_q.char_in_field < ADDR_LEN) begin
							if (char_in != gga_char(state_q.char_in_field[2:0])) begin
								state_d.kind_match[0] = 1'b0;
							end
							if (char_in != rmc_char(state_q.char_in_field[2:0])) begin
								state_d.kind_match[1] = 1'b0;
							end
						end else begin
							state_d.kind_match = 2'b00;
						end
					end
					FLD_TIME: begin
						if (!state_q.past_point) begin
							if (is_digit(char_in)) begin
								state_d.time_digits = {state_q.time_digits[19:0], char_in[3:0]};
							end else begin
								state_d.past_point = 1'b1;
							end
						end
					end
					FLD_STATUS: begin
						if (state_q.char_in_field == 4'd0) begin
							state_d.status_active = (char_in == CH_UA);
						end
					end
					FLD_QUALITY: begin
						if (!state_q.past_point) begin
							if (is_digit(char_in)) begin
								state_d.quality_value = add_count(state_q.quality_value,
									char_in[3:0]);
							end else begin
								state_d.past_point = 1'b1;
							end
						end
					end
					FLD_SATS: begin
						if (!state_q.past_point) begin
							if (is_digit(char_in)) begin
								state_d.satellite_value = add_count(state_q.satellite_value,
									char_in[3:0]);
							end else begin
								state_d.past_point = 1'b1;
							end
						end
					end
					FLD_DATE: begin
						if (!state_q.past_point) begin
							if (is_digit(char_in)) begin
								state_d.date_digits = {state_q.date_digits[19:0], char_in[3:0]};
							end else begin
								state_d.past_point = 1'b1;
							end
						end
					end
					default: begin
					end
				endcase
				if (state_q.char_in_field != COUNT_MAX) begin
					state_d.char_in_field = state_q.char_in_field + 4'd1;
				end
			end
		end
	end

	always_comb begin
		raw.kind            = state_q.kind_match[0] ? KIND_GGA :
		                      (state_q.kind_match[1] ? KIND_RMC : KIND_UNKNOWN);
		raw.checksum_ok     = (state_q.xor_sum == sum_check);
		raw.time_digits     = state_q.time_digits;
		raw.date_digits     = state_q.date_digits;
		raw.quality_value   = state_q.quality_value;
		raw.satellite_value = state_q.satellite_value;
		raw.status_active   = state_q.status_active;
	end

	assign emit = step && emit_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= idle_state();
		end else if (step) begin
			state_q <= state_d;
		end
	end

	// Two hex digits always close the sentence.
	a_hex_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.in_sentence |-> (state_q.hex_digits_seen != 2'd2))
		else $error("open sentence holds two checksum digits");

	// An address can never match both sentence names once it is closed.
	a_kind_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.in_sentence && state_q.after_star) |-> (state_q.kind_match != 2'b11))
		else $error("address matched both sentence kinds");

	// After a result the sentence is either closed or freshly opened.
	a_emit_close: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (!state_q.in_sentence ||
		          (state_q.field_number == 4'd0 && state_q.xor_sum == 8'd0)))
		else $error("sentence state survived a result");

endmodule

### hdl/nsc_result.sv
// ----------------------------------------------------------------------------
// nsc_result: result formatting and output register
// Turns the raw BCD and count fields into the result item and holds it
// until the receiver takes it.
// ----------------------------------------------------------------------------
module nsc_result import nsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  raw_result_t raw,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [1:0]  sentence_kind,
	output logic        checksum_ok,
	output logic [6:0]  hour,
	output logic [6:0]  minute,
	output logic [6:0]  second,
	output logic        rmc_active,
	output logic [6:0]  day,
	output logic [7:0]  month_index,
	output logic [7:0]  year_offset,
	output logic [6:0]  fix_quality,
	output logic [6:0]  satellites
);

	logic       out_valid_q;
	logic [1:0] kind_q;
	logic       ok_q;
	logic [6:0] hour_q, minute_q, second_q, day_q, quality_q, sats_q;
	logic       active_q;
	logic [7:0] month_q, year_q;
	logic       known, is_gga, rmc_date;
	logic [6:0] year_pair;

	assign known     = (raw.kind != KIND_UNKNOWN);
	assign is_gga    = (raw.kind == KIND_GGA);
	assign rmc_date  = (raw.kind == KIND_RMC) && raw.status_active;
	assign year_pair = digit_pair(raw.date_digits[7:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q    <= raw.kind;
			ok_q      <= raw.checksum_ok;
			hour_q    <= known ? digit_pair(raw.time_digits[23:16]) : 7'd0;
			minute_q  <= known ? digit_pair(raw.time_digits[15:8]) : 7'd0;
			second_q  <= known ? digit_pair(raw.time_digits[7:0]) : 7'd0;
			quality_q <= is_gga ? raw.quality_value : 7'd0;
			sats_q    <= is_gga ? raw.satellite_value : 7'd0;
			active_q  <= rmc_date;
			day_q     <= rmc_date ? digit_pair(raw.date_digits[23:16]) : 7'd0;
			month_q   <= rmc_date ? ({1'b0, digit_pair(raw.date_digits[15:8])} - 8'd1) : 8'd0;
			year_q    <= rmc_date ? ((year_pair < YEAR_WRAP) ? ({1'b0, year_pair} + YEAR_ADD)
			                                                 : {1'b0, year_pair}) : 8'd0;
		end
	end

	assign out_valid     = out_valid_q;
	assign sentence_kind = kind_q;
	assign checksum_ok   = ok_q;
	assign hour          = hour_q;
	assign minute        = minute_q;
	assign second        = second_q;
	assign rmc_active    = active_q;
	assign day           = day_q;
	assign month_index   = month_q;
	assign year_offset   = year_q;
	assign fix_quality   = quality_q;
	assign satellites    = sats_q;

endmodule

### hdl/nmea_sentence_checker_top.sv
// ----------------------------------------------------------------------------
// nmea_sentence_checker_top: NMEA 0183 sentence checker
// Parses a character stream into one checked result item per sentence.
// ----------------------------------------------------------------------------
// Usage:
// The rx channel (rx_valid, rx_ready, rx_byte) takes one received character
// per item. A dollar sign opens a sentence; the body is XORed up to the star
// and compared with up to two hex digits after it. The out channel
// (out_valid, out_ready and the result fields) gives one item per sentence,
// carrying the sentence kind, the checksum verdict, the UTC time and the
// GGA or RMC specific fields.
// Throughput is one character per clock while results are taken; a held
// result with a waiting character stalls the input. A character is first
// captured in an input register; the parser then folds it into its state,
// and the result of a closing character is loaded into the output register
// on the same edge that the parser state is updated.
// Reset (arst_n low) drops any open sentence and empties both registers.
// When the receiver stalls, the result waits in the output register and the
// character behind it waits in the input register; rx_ready falls only while
// both are occupied and the result has not been taken.
// ----------------------------------------------------------------------------
module nmea_sentence_checker_top import nsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] sentence_kind,
	output logic       checksum_ok,
	output logic [6:0] hour,
	output logic [6:0] minute,
	output logic [6:0] second,
	output logic       rmc_active,
	output logic [6:0] day,
	output logic [7:0] month_index,
	output logic [7:0] year_offset,
	output logic [6:0] fix_quality,
	output logic [6:0] satellites
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        advance;
	logic        step;
	logic        emit;
	raw_result_t raw;

	// The parser may take a character whenever the output register can
	// accept whatever result that character produces.
	assign advance  = !out_valid || out_ready;
	assign step     = valid_s1 && advance;
	assign rx_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	nsc_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.char_in (byte_s1),
		.emit    (emit),
		.raw     (raw)
	);

	nsc_result u_result (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (emit),
		.raw           (raw),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.sentence_kind (sentence_kind),
		.checksum_ok   (checksum_ok),
		.hour          (hour),
		.minute        (minute),
		.second        (second),
		.rmc_active    (rmc_active),
		.day           (day),
		.month_index   (month_index),
		.year_offset   (year_offset),
		.fix_quality   (fix_quality),
		.satellites    (satellites)
	);

	// Input backpressure only comes from a held result with a waiting character.
	a_rx_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!rx_ready |-> (valid_s1 && out_valid && !out_ready))
		else $error("rx stalled without a held result");

	// A result is only produced by a character the parser actually takes.
	a_emit_step: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (valid_s1 && advance))
		else $error("result produced without a parser step");

	// A new result appears only when the previous one has been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !emit)
		else $error("held result overwritten");

endmodule

### bench/tb_nmea_sentence_checker_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nmea_sentence_checker_top: self-checking bench for the NMEA checker
// Feeds a table of hand-written sentences and then a long run of random
// sentences, one character per item. Every accepted character also drives
// a behavioral sentence tracker, and each result item of the block is
// compared field by field with the oldest predicted sentence.
// ----------------------------------------------------------------------------
module tb_nmea_sentence_checker_top
	import nsc_pkg::*;
();

	localparam int          ITEM_TARGET  = 1550;
	localparam int          STALL_CYCLES = 600;
	localparam int          QUIET_LIMIT  = 4000;
	localparam int          SETTLE       = 8;
	localparam logic [7:0]  CH_CR        = 8'h0D;
	localparam logic [7:0]  CH_POINT     = 8'h2E;
	localparam logic [7:0]  CH_UV        = 8'h56;
	localparam logic [39:0] GGA_TAG      = "GPGGA";
	localparam logic [39:0] RMC_TAG      = "GPRMC";

	// How a stimulus sentence is closed after its body has been sent.
	typedef enum int {
		CK_AS_IS,  // nothing appended: the text is sent exactly as written
		CK_GOOD,   // star and the correct checksum in upper case
		CK_LOWER,  // star and the correct checksum in lower case
		CK_BAD,    // star and a wrong two-digit checksum
		CK_SHORT,  // star, one hex digit, then a carriage return
		CK_NONE,   // star followed straight by a carriage return
		CK_OPEN    // star only; whatever comes next closes the sentence
	} ck_mode_t;

	// One result item, laid out like the output ports.
	typedef struct packed {
		logic [1:0] kind;
		logic       ok;
		logic [6:0] hour;
		logic [6:0] minute;
		logic [6:0] second;
		logic       active;
		logic [6:0] day;
		logic [7:0] month_idx;
		logic [7:0] year_off;
		logic [6:0] quality;
		logic [6:0] sats;
	} sentence_t;

	// Running parse state of the sentence tracker.
	typedef struct packed {
		logic        busy;     // inside a sentence
		logic [7:0]  sum;      // XOR of the body
		logic        star;     // checksum digits are being read
		logic [1:0]  hex_n;
		logic [7:0]  ck;       // transmitted checksum
		logic [3:0]  field;
		logic [3:0]  pos;      // character index inside the field
		logic [1:0]  cand;     // bit 0 GGA still possible, bit 1 RMC
		logic        halt;     // number in this field has ended
		logic [23:0] tdig;
		logic [23:0] ddig;
		logic [6:0]  qual;
		logic [6:0]  sats;
		logic        act;
	} tracker_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       rx_valid;
	logic       rx_ready;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_ready;
	logic [1:0] sentence_kind;
	logic       checksum_ok;
	logic [6:0] hour;
	logic [6:0] minute;
	logic [6:0] second;
	logic       rmc_active;
	logic [6:0] day;
	logic [7:0] month_index;
	logic [7:0] year_offset;
	logic [6:0] fix_quality;
	logic [6:0] satellites;

	tracker_t  trk;
	sentence_t sentence_q[$];

	// Directed stimulus table, one row per sentence.
	string     row_text[$];
	ck_mode_t  row_mode[$];
	bit        row_typed[$];
	sentence_t row_exp[$];

	// While a typed row is being sent, its own expectation replaces the
	// tracker's prediction for the one sentence that row closes.
	bit        typed_pending = 1'b0;
	sentence_t typed_exp;

	logic [7:0] gen_xor = 8'h00;   // XOR of the stimulus since its last dollar
	bit         burst = 1'b0;      // no idle gaps on the sender side
	bit         hold_off_req = 1'b0;
	int         chars_sent = 0;
	int         results_seen = 0;
	int         mismatch_count = 0;
	int         gga_seen = 0;
	int         rmc_seen = 0;
	int         unknown_seen = 0;
	int         bad_ck_seen = 0;
	int         stalls_asked = 0;

	always #5 clk = ~clk;

	nmea_sentence_checker_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_valid     (rx_valid),
		.rx_ready     (rx_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sentence_kind(sentence_kind),
		.checksum_ok  (checksum_ok),
		.hour         (hour),
		.minute       (minute),
		.second       (second),
		.rmc_active   (rmc_active),
		.day          (day),
		.month_index  (month_index),
		.year_offset  (year_offset),
		.fix_quality  (fix_quality),
		.satellites   (satellites)
	);

	// ------------------------------------------------------------------
	// Sentence tracker
	// ------------------------------------------------------------------

	// A freshly opened sentence: both address candidates still possible.
	function automatic tracker_t fresh_tracker();
		tracker_t t;
		t      = '0;
		t.busy = 1'b1;
		t.cand = 2'b11;
		return t;
	endfunction

	function automatic bit is_dec(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	// Bit 4 set when the byte is a hex digit, bits 3:0 hold its value.
	function automatic logic [4:0] nibble_of(input logic [7:0] b);
		if (is_dec(b)) begin
			return {1'b1, b[3:0]};
		end
		if ((b >= CH_UA) && (b <= CH_UF)) begin
			return {1'b1, 4'(b - CH_UA + 8'd10)};
		end
		if ((b >= CH_LA) && (b <= CH_LF)) begin
			return {1'b1, 4'(b - CH_LA + 8'd10)};
		end
		return 5'd0;
	endfunction

	function automatic int bcd_pair(input logic [7:0] r);
		return int'(r[7:4]) * 10 + int'(r[3:0]);
	endfunction

	// Time and date keep their last six decimal digits; the first
	// non-digit freezes the field.
	function automatic logic [23:0] push_bcd(input logic [23:0] r, input logic [7:0] b);
		if (trk.halt) begin
			return r;
		end
		if (!is_dec(b)) begin
			trk.halt = 1'b1;
			return r;
		end
		return {r[19:0], b[3:0]};
	endfunction

	// Quality and satellite counts saturate at 99.
	function automatic logic [6:0] push_count(input logic [6:0] v, input logic [7:0] b);
		int n;
		if (trk.halt) begin
			return v;
		end
		if (!is_dec(b)) begin
			trk.halt = 1'b1;
			return v;
		end
		n = int'(v) * 10 + int'(b[3:0]);
		return (n > 99) ? 7'd99 : 7'(n);
	endfunction

	// An address is only recognized when it is exactly five characters long.
	function automatic void end_address();
		if ((trk.field == FLD_ADDRESS) && (trk.pos != ADDR_LEN)) begin
			trk.cand = 2'b00;
		end
	endfunction

	task automatic emit_sentence();
		sentence_t s;
		int        yr;
		s = '0;
		if (trk.cand[0]) begin
			s.kind = KIND_GGA;
		end else if (trk.cand[1]) begin
			s.kind = KIND_RMC;
		end else begin
			s.kind = KIND_UNKNOWN;
		end
		s.ok = (trk.sum == trk.ck);
		if (s.kind != KIND_UNKNOWN) begin
			s.hour   = 7'(bcd_pair(trk.tdig[23:16]));
			s.minute = 7'(bcd_pair(trk.tdig[15:8]));
			s.second = 7'(bcd_pair(trk.tdig[7:0]));
		end
		if (s.kind == KIND_GGA) begin
			s.quality = trk.qual;
			s.sats    = trk.sats;
		end else if ((s.kind == KIND_RMC) && trk.act) begin
			yr          = bcd_pair(trk.ddig[7:0]);
			s.active    = 1'b1;
			s.day       = 7'(bcd_pair(trk.ddig[23:16]));
			s.month_idx = 8'(bcd_pair(trk.ddig[15:8]) + 255);
			s.year_off  = 8'((yr < 90) ? yr + 100 : yr);
		end
		if (typed_pending) begin
			sentence_q.push_back(typed_exp);
			typed_pending = 1'b0;
		end else begin
			sentence_q.push_back(s);
		end
	endtask

	// Advances the tracker by one accepted character.
	task automatic follow_char(input logic [7:0] b);
		logic [4:0] h;
		int         p;
		if (!trk.busy) begin
			if (b == CH_DOLLAR) begin
				trk = fresh_tracker();
			end
			return;
		end
		if (trk.star) begin
			h = nibble_of(b);
			if (h[4]) begin
				trk.ck    = {trk.ck[3:0], h[3:0]};
				trk.hex_n = trk.hex_n + 2'd1;
				if (trk.hex_n < 2'd2) begin
					return;
				end
				emit_sentence();
				trk.busy = 1'b0;
				return;
			end
			// Any other byte closes the sentence; a dollar reopens at once.
			emit_sentence();
			trk.busy = 1'b0;
			if (b == CH_DOLLAR) begin
				trk = fresh_tracker();
			end
			return;
		end
		// A dollar inside the body drops the open sentence silently.
		if (b == CH_DOLLAR) begin
			trk = fresh_tracker();
			return;
		end
		if (b == CH_STAR) begin
			end_address();
			trk.star = 1'b1;
			return;
		end
		trk.sum = trk.sum ^ b;
		if (b == CH_COMMA) begin
			end_address();
			if (trk.field < COUNT_MAX) begin
				trk.field = trk.field + 4'd1;
			end
			trk.pos  = 4'd0;
			trk.halt = 1'b0;
			return;
		end
		case (trk.field)
			FLD_ADDRESS: begin
				if (trk.pos < ADDR_LEN) begin
					p = int'(trk.pos);
					if (b != GGA_TAG[39 - 8 * p -: 8]) trk.cand = trk.cand & 2'b10;
					if (b != RMC_TAG[39 - 8 * p -: 8]) trk.cand = trk.cand & 2'b01;
				end else begin
					trk.cand = 2'b00;
				end
			end
			FLD_TIME:    trk.tdig = push_bcd(trk.tdig, b);
			FLD_STATUS:  if (trk.pos == 4'd0) trk.act = (b == CH_UA);
			FLD_QUALITY: trk.qual = push_count(trk.qual, b);
			FLD_SATS:    trk.sats = push_count(trk.sats, b);
			FLD_DATE:    trk.ddig = push_bcd(trk.ddig, b);
			default:     ;
		endcase
		if (trk.pos < COUNT_MAX) begin
			trk.pos = trk.pos + 4'd1;
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Offers one character, may idle first unless in a burst, and waits for
	// the handshake. The tracker only sees characters once they are accepted.
	task automatic offer_char(input logic [7:0] b);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= b;
		do begin
			@(posedge clk);
		end while (!rx_ready);
		follow_char(b);
		chars_sent++;
		if (b == CH_DOLLAR) begin
			gen_xor = 8'h00;
		end else begin
			gen_xor = gen_xor ^ b;
		end
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
		if (n < 4'd10) begin
			return CH_ZERO + 8'(n);
		end
		return (lower ? CH_LA : CH_UA) + 8'(n) - 8'd10;
	endfunction

	// A body character that never splits or ends the sentence; about a
	// quarter of them come from the full byte range.
	function automatic logic [7:0] junk_char();
		logic [7:0] c;
		if ($urandom_range(0, 3) == 0) begin
			c = 8'($urandom_range(0, 255));
		end else begin
			c = 8'($urandom_range(32, 126));
		end
		if ((c == CH_DOLLAR) || (c == CH_STAR) || (c == CH_COMMA)) begin
			c = CH_POINT;
		end
		return c;
	endfunction

	task automatic offer_digits(input int n);
		int i;
		for (i = 0; i < n; i++) begin
			offer_char(CH_ZERO + 8'($urandom_range(0, 9)));
		end
	endtask

	task automatic offer_junk(input int n);
		int i;
		for (i = 0; i < n; i++) begin
			offer_char(junk_char());
		end
	endtask

	// Closes the sentence body in the requested way.
	task automatic close_sentence(input ck_mode_t mode);
		logic [7:0] ck;
		ck = gen_xor;
		if (mode == CK_AS_IS) begin
			return;
		end
		offer_char(CH_STAR);
		case (mode)
			CK_GOOD: begin
				offer_char(hex_char(ck[7:4], 1'b0));
				offer_char(hex_char(ck[3:0], 1'b0));
			end
			CK_LOWER: begin
				offer_char(hex_char(ck[7:4], 1'b1));
				offer_char(hex_char(ck[3:0], 1'b1));
			end
			CK_BAD: begin
				ck = ck ^ 8'($urandom_range(1, 255));
				offer_char(hex_char(ck[7:4], 1'b0));
				offer_char(hex_char(ck[3:0], 1'b1));
			end
			CK_SHORT: begin
				offer_char(hex_char(ck[7:4], 1'b0));
				offer_char(CH_CR);
			end
			CK_NONE: offer_char(CH_CR);
			default: ;
		endcase
	endtask

	// Mostly GGA and RMC sentences with random content; the rest have broken
	// addresses or odd field counts, and any of them may get a broken ending.
	task automatic offer_random_sentence();
		int         style;
		int         nf;
		int         f;
		int         n;
		int         i;
		int         e;
		logic [39:0] tag;
		logic [7:0] c;
		ck_mode_t   mode;
		style = $urandom_range(0, 9);
		burst = ($urandom_range(0, 3) == 0);
		if (style < 4) begin
			tag = GGA_TAG;
		end else if (style < 8) begin
			tag = RMC_TAG;
		end else begin
			tag = ($urandom_range(0, 1) == 0) ? GGA_TAG : RMC_TAG;
		end
		offer_char(CH_DOLLAR);
		n = 5;
		if (style >= 8) begin
			n = $urandom_range(0, 8);
			if (n == 8) n = 17;
		end
		for (i = 0; i < n; i++) begin
			c = (i < 5) ? tag[39 - 8 * i -: 8] : junk_char();
			if ((style >= 8) && ($urandom_range(0, 4) == 0)) c = junk_char();
			offer_char(c);
		end
		if (style < 4) begin
			nf = $urandom_range(7, 10);
		end else if (style < 8) begin
			nf = $urandom_range(9, 12);
		end else begin
			nf = $urandom_range(0, 17);
		end
		for (f = 1; f <= nf; f++) begin
			offer_char(CH_COMMA);
			case (f)
				1, 9: begin
					offer_digits(($urandom_range(0, 3) != 0) ? 6 : $urandom_range(0, 8));
					if ($urandom_range(0, 1) == 1) begin
						offer_char(CH_POINT);
						offer_digits($urandom_range(0, 2));
					end
				end
				2: begin
					e = $urandom_range(0, 4);
					if (e < 3) begin
						offer_char(CH_UA);
					end else if (e == 3) begin
						offer_char(CH_UV);
					end else begin
						offer_junk($urandom_range(0, 2));
					end
				end
				6, 7: begin
					offer_digits($urandom_range(0, 3));
					if ($urandom_range(0, 4) == 0) begin
						offer_junk(1);
						offer_digits(1);
					end
				end
				default: if ($urandom_range(0, 1) == 1) offer_junk($urandom_range(0, 3));
			endcase
		end
		e = $urandom_range(0, 99);
		if (e < 55)      mode = CK_GOOD;
		else if (e < 65) mode = CK_BAD;
		else if (e < 73) mode = CK_LOWER;
		else if (e < 80) mode = CK_SHORT;
		else if (e < 86) mode = CK_NONE;
		else if (e < 92) mode = CK_OPEN;
		else             mode = CK_AS_IS;
		close_sentence(mode);
		// Line noise between sentences; never a dollar, so it cannot open one.
		n = $urandom_range(0, 2);
		for (i = 0; i < n; i++) begin
			c = 8'($urandom_range(0, 255));
			if (c == CH_DOLLAR) c = CH_CR;
			offer_char(c);
		end
	endtask

	function automatic sentence_t typed_result(
		input int kind, input int ok, input int h, input int m, input int s,
		input int act, input int d, input int mi, input int yo, input int q,
		input int n);
		sentence_t r;
		r.kind      = 2'(kind);
		r.ok        = 1'(ok);
		r.hour      = 7'(h);
		r.minute    = 7'(m);
		r.second    = 7'(s);
		r.active    = 1'(act);
		r.day       = 7'(d);
		r.month_idx = 8'(mi);
		r.year_off  = 8'(yo);
		r.quality   = 7'(q);
		r.sats      = 7'(n);
		return r;
	endfunction

	function automatic void add_row(input string txt, input ck_mode_t mode,
		input bit typed, input sentence_t exp);
		row_text.push_back(txt);
		row_mode.push_back(mode);
		row_typed.push_back(typed);
		row_exp.push_back(exp);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		if (mismatch_count <= 100) begin
			$display("ERROR: result item %0d, %s: got %0d, expected %0d",
				results_seen, what, got, want);
		end
	endtask

	// ------------------------------------------------------------------
	// Output side: random back-pressure and the field-by-field check
	// ------------------------------------------------------------------
	initial begin
		sentence_t got;
		sentence_t want;
		int        hold;
		hold      = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got.kind      = sentence_kind;
				got.ok        = checksum_ok;
				got.hour      = hour;
				got.minute    = minute;
				got.second    = second;
				got.active    = rmc_active;
				got.day       = day;
				got.month_idx = month_index;
				got.year_off  = year_offset;
				got.quality   = fix_quality;
				got.sats      = satellites;
				results_seen++;
				if (sentence_q.size() == 0) begin
					report_mismatch("item with no sentence pending", 1, 0);
				end else begin
					want = sentence_q.pop_front();
					if (want.kind == KIND_GGA)      gga_seen++;
					else if (want.kind == KIND_RMC) rmc_seen++;
					else                            unknown_seen++;
					if (!want.ok) bad_ck_seen++;
					if (got.kind != want.kind)
						report_mismatch("sentence_kind", got.kind, want.kind);
					if (got.ok != want.ok)
						report_mismatch("checksum_ok", got.ok, want.ok);
					if (got.hour != want.hour)
						report_mismatch("hour", got.hour, want.hour);
					if (got.minute != want.minute)
						report_mismatch("minute", got.minute, want.minute);
					if (got.second != want.second)
						report_mismatch("second", got.second, want.second);
					if (got.active != want.active)
						report_mismatch("rmc_active", got.active, want.active);
					if (got.day != want.day)
						report_mismatch("day", got.day, want.day);
					if (got.month_idx != want.month_idx)
						report_mismatch("month_index", got.month_idx, want.month_idx);
					if (got.year_off != want.year_off)
						report_mismatch("year_offset", got.year_off, want.year_off);
					if (got.quality != want.quality)
						report_mismatch("fix_quality", got.quality, want.quality);
					if (got.sats != want.sats)
						report_mismatch("satellites", got.sats, want.sats);
				end
				// About a quarter of the items are taken back to back.
				hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
			end else if (hold > 0) begin
				hold--;
			end
			// A long hold-off lets both internal registers fill so that the
			// block has to drop rx_ready while the sender keeps offering.
			if (hold_off_req) begin
				hold         = STALL_CYCLES;
				hold_off_req = 1'b0;
			end
			out_ready <= (hold == 0);
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: ends the run when no item moves on either channel for
	// far longer than any correct run could take.
	// ------------------------------------------------------------------
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((rx_valid && rx_ready) || (out_valid && out_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
			if (quiet >= QUIET_LIMIT) begin
				$display("ERROR: no item moved for %0d cycles, %0d sentences still pending",
					quiet, sentence_q.size());
				$display("** nmea_sentence_checker_top: FAILED **");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int r;
		int i;
		int random_sentences;
		arst_n   = 1'b0;
		rx_valid = 1'b0;
		rx_byte  = 8'h00;
		trk      = fresh_tracker();
		trk.busy = 1'b0;

		// Rows with a typed expectation come first, while the checker is known
		// to be outside any sentence, so each of them closes exactly its own
		// sentence. Every typed row ends on its second checksum digit.
		add_row("$", CK_GOOD, 1,
			typed_result(KIND_UNKNOWN, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		add_row("$GPGGA", CK_GOOD, 1,
			typed_result(KIND_GGA, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		add_row("$GPGGA,235959.99,,,,,9,99", CK_GOOD, 1,
			typed_result(KIND_GGA, 1, 23, 59, 59, 0, 0, 0, 0, 9, 99));
		// Quality and satellite counts both run past 99 and saturate.
		add_row("$GPGGA,000000,,,,,150,123", CK_BAD, 1,
			typed_result(KIND_GGA, 0, 0, 0, 0, 0, 0, 0, 0, 99, 99));
		add_row("$GPRMC,123456,A,,,,,,,311299", CK_GOOD, 1,
			typed_result(KIND_RMC, 1, 12, 34, 56, 1, 31, 11, 99, 0, 0));
		// Month zero wraps to 255, year 89 gets the century added.
		add_row("$GPRMC,999999,A,,,,,,,990089", CK_GOOD, 1,
			typed_result(KIND_RMC, 1, 99, 99, 99, 1, 99, 255, 189, 0, 0));
		add_row("$GPRMC,010203,A,,,,,,,010100", CK_BAD, 1,
			typed_result(KIND_RMC, 0, 1, 2, 3, 1, 1, 0, 100, 0, 0));
		add_row("$GPRMC,235959,A,,,,,,,010190", CK_GOOD, 1,
			typed_result(KIND_RMC, 1, 23, 59, 59, 1, 1, 0, 90, 0, 0));
		// A void status hides the date.
		add_row("$GPRMC,010203,V,,,,,,,311299", CK_GOOD, 1,
			typed_result(KIND_RMC, 1, 1, 2, 3, 0, 0, 0, 0, 0, 0));
		add_row("$GPGGAX,1234", CK_GOOD, 1,
			typed_result(KIND_UNKNOWN, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		add_row("$GPGG,1234", CK_BAD, 1,
			typed_result(KIND_UNKNOWN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

		// The remaining rows are checked against the tracker only.
		add_row("\015\012noise#", CK_AS_IS, 0, '0);
		add_row("$GPGGA,12:34:56,,,,,1x5,1.2", CK_LOWER, 0, '0);
		add_row("$GPRMC,12345678,A,,,,,,,3112991", CK_SHORT, 0, '0);
		add_row("$GPRMC,,Active,,,,,,,,,,,,,,,,,,,,x", CK_NONE, 0, '0);
		add_row("$GPGGA,120000$GPRMC,0102,V", CK_GOOD, 0, '0);
		// One checksum digit, then a dollar that closes and reopens at once;
		// the next row carries on inside that new sentence.
		add_row("$GPRMC,1,A*5$", CK_AS_IS, 0, '0);
		add_row("GPGGA,1,,,,,,7", CK_GOOD, 0, '0);
		add_row("$*A\015", CK_AS_IS, 0, '0);
		add_row("$,,,,,,,,,,", CK_BAD, 0, '0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < row_text.size(); r++) begin
			typed_pending = row_typed[r];
			typed_exp     = row_exp[r];
			burst         = ($urandom_range(0, 2) == 0);
			for (i = 0; i < row_text[r].len(); i++) begin
				offer_char(row_text[r][i]);
			end
			close_sentence(row_mode[r]);
		end

		// Random part, with up to two long output stalls along the way.
		random_sentences = 0;
		while (chars_sent < ITEM_TARGET) begin
			if ((random_sentences == 10) || (random_sentences == 30)) begin
				hold_off_req = 1'b1;
				stalls_asked++;
			end
			offer_random_sentence();
			random_sentences++;
		end
		rx_valid <= 1'b0;

		// Drain, then give the pipeline time to show any stray result item.
		while (sentence_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);

		$display("Sent %0d characters: %0d table rows and %0d random sentences, %0d long stalls.",
			chars_sent, row_text.size(), random_sentences, stalls_asked);
		$display("Checked %0d result items: %0d GGA, %0d RMC, %0d unknown, %0d bad checksums.",
			results_seen, gga_seen, rmc_seen, unknown_seen, bad_ck_seen);
		if (mismatch_count == 0) begin
			$display("** nmea_sentence_checker_top: PASSED **");
		end else begin
			$display("%0d mismatches found", mismatch_count);
			$display("** nmea_sentence_checker_top: FAILED **");
		end
		$finish;
	end

endmodule

### files.f
hdl/nsc_pkg.sv
hdl/nsc_parser.sv
hdl/nsc_result.sv
hdl/nmea_sentence_checker_top.sv
bench/tb_nmea_sentence_checker_top.sv
